// ----- rtl/tbn_pkg.sv -----
`timescale 1ns / 1ps
// shared types, widths and constants for the triangle tangent/binormal block
// no dependencies; imported by every module of the block

package tbn_pkg;

    // vertex position width, signed Q16.16 at the default of 32
    localparam int POS_WIDTH = 32;

    // texture coordinates and their differences
    localparam int TEX_W  = 16;
    localparam int TEXD_W = TEX_W + 1;

    // edge differences, and the width they are cut to after edge scaling
    localparam int EDGE_W = POS_WIDTH + 1;
    localparam int MUL_W  = 32;

    // unscaled tangent/binormal components: texd * edge, then a difference
    localparam int VEC_W  = TEXD_W + MUL_W + 1;
    localparam int DET_W  = 2 * TEXD_W + 1;

    // length and division path
    localparam int MAG_W  = 31;
    localparam int SQ_W   = 64;
    localparam int LEN_W  = 32;
    localparam int NUM_W  = 46;
    localparam int Q_W    = 16;
    localparam int FRAC_SH = 14;
    localparam int OUT_W  = 16;

    // step counter for the back end sequencer
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_LAST3  = STEP_W'(2);
    localparam logic [STEP_W-1:0] STEP_LAST4  = STEP_W'(3);
    localparam logic [STEP_W-1:0] STEP_LASTQ  = STEP_W'(Q_W - 1);
    localparam logic [STEP_W-1:0] STEP_LASTSQ = STEP_W'(SQ_W / 2 - 1);

    // scaling window for the largest component magnitude
    localparam logic [SQ_W-1:0] LIM29 = SQ_W'(1) << 29;
    localparam logic [SQ_W-1:0] LIM30 = SQ_W'(1) << 30;
    localparam logic [SQ_W-1:0] SQRT_BIT0 = SQ_W'(1) << (SQ_W - 2);

    // stream widths
    localparam int IN_BITS     = 3 * POS_WIDTH + 2 * TEX_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 6 * OUT_W;

    // triangle assembly
    localparam logic [1:0] CORNER_LAST = 2'd2;

    // request queue between front and back end
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // one assembled triangle, as handed from front to back end
    typedef struct packed {
        logic signed [EDGE_W-1:0] e1_x;
        logic signed [EDGE_W-1:0] e1_y;
        logic signed [EDGE_W-1:0] e1_z;
        logic signed [EDGE_W-1:0] e2_x;
        logic signed [EDGE_W-1:0] e2_y;
        logic signed [EDGE_W-1:0] e2_z;
        logic signed [TEXD_W-1:0] du1;
        logic signed [TEXD_W-1:0] dv1;
        logic signed [TEXD_W-1:0] du2;
        logic signed [TEXD_W-1:0] dv2;
    } tri_rec_t;

    // queue handshake seen by the back end
    typedef struct packed {
        logic avail;
        logic pop;
    } q_hs_t;

    // back end sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EMAX,
        ST_ESHIFT,
        ST_DET,
        ST_MUL,
        ST_VMAX,
        ST_VSHIFT,
        ST_SQ,
        ST_SQRT,
        ST_DINIT,
        ST_DIV,
        ST_EMIT
    } back_state_t;

endpackage

// ----- rtl/tbn_front.sv -----
`timescale 1ns / 1ps
// front end: takes vertices, holds the first two corners of each triangle and
// pushes edge and texture differences of a finished triangle; uses tbn_pkg

module tbn_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v from the lowest bit up
    input  logic [tbn_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    // start_mesh
    input  logic                           s_axis_tuser,
    input  logic                           q_full,
    output logic                           q_push,
    output tbn_pkg::tri_rec_t              q_rec
);
    import tbn_pkg::*;

    logic                        accept;
    logic [1:0]                  corner_eff;
    logic [1:0]                  corner_count_reg;
    logic [1:0]                  corner_count_next;
    logic signed [POS_WIDTH-1:0] pos [3];
    logic signed [TEX_W-1:0]     tex_u;
    logic signed [TEX_W-1:0]     tex_v;
    logic signed [POS_WIDTH-1:0] held_pos_reg [2][3];
    logic signed [TEX_W-1:0]     held_u_reg [2];
    logic signed [TEX_W-1:0]     held_v_reg [2];

    // unpack the vertex
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pos[i] = s_axis_tdata[i*POS_WIDTH +: POS_WIDTH];
        end
        tex_u = s_axis_tdata[3*POS_WIDTH +: TEX_W];
        tex_v = s_axis_tdata[3*POS_WIDTH+TEX_W +: TEX_W];
    end

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign corner_eff    = s_axis_tuser ? 2'd0 : corner_count_reg;
    assign q_push        = accept && (corner_eff == CORNER_LAST);

    // corner counter
    always_comb
    begin
        corner_count_next = corner_count_reg;
        if (accept)
        begin
            corner_count_next = (corner_eff == CORNER_LAST) ? 2'd0 : corner_eff + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_count_reg <= 2'd0;
        end
        else
        begin
            corner_count_reg <= corner_count_next;
        end
    end

    // held corners
    always_ff @(posedge clk)
    begin
        if (accept && (corner_eff != CORNER_LAST))
        begin
            for (int i = 0; i < 3; i++)
            begin
                held_pos_reg[corner_eff[0]][i] <= pos[i];
            end
            held_u_reg[corner_eff[0]] <= tex_u;
            held_v_reg[corner_eff[0]] <= tex_v;
        end
    end

    // edge and texture differences of the finished triangle
    always_comb
    begin
        q_rec.e1_x = EDGE_W'(held_pos_reg[1][0]) - EDGE_W'(held_pos_reg[0][0]);
        q_rec.e1_y = EDGE_W'(held_pos_reg[1][1]) - EDGE_W'(held_pos_reg[0][1]);
        q_rec.e1_z = EDGE_W'(held_pos_reg[1][2]) - EDGE_W'(held_pos_reg[0][2]);
        q_rec.e2_x = EDGE_W'(pos[0]) - EDGE_W'(held_pos_reg[0][0]);
        q_rec.e2_y = EDGE_W'(pos[1]) - EDGE_W'(held_pos_reg[0][1]);
        q_rec.e2_z = EDGE_W'(pos[2]) - EDGE_W'(held_pos_reg[0][2]);
        q_rec.du1  = TEXD_W'(held_u_reg[1]) - TEXD_W'(held_u_reg[0]);
        q_rec.dv1  = TEXD_W'(held_v_reg[1]) - TEXD_W'(held_v_reg[0]);
        q_rec.du2  = TEXD_W'(tex_u) - TEXD_W'(held_u_reg[0]);
        q_rec.dv2  = TEXD_W'(tex_v) - TEXD_W'(held_v_reg[0]);
    end

endmodule

// ----- rtl/tbn_fifo.sv -----
`timescale 1ns / 1ps
// short register queue of assembled triangles between front and back end
// uses tri_rec_t and the queue depth from tbn_pkg

module tbn_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tbn_pkg::tri_rec_t din,
    output logic              full,
    input  tbn_pkg::q_hs_t    hs_in,
    output logic              avail,
    output tbn_pkg::tri_rec_t dout
);
    import tbn_pkg::*;

    tri_rec_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [FIFO_AW:0]     count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign full    = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign avail   = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop  = hs_in.pop && avail;
    assign dout    = mem_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- rtl/tbn_back.sv -----
`timescale 1ns / 1ps
// back end: scales edges, forms tangent and binormal, normalizes them with a
// bit-serial square root and divider, and holds the result; uses tbn_pkg

module tbn_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_avail,
    input  tbn_pkg::tri_rec_t               q_rec,
    output tbn_pkg::q_hs_t                  q_hs,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tangent_x, tangent_y, tangent_z, binormal_x, binormal_y, binormal_z
    output logic [tbn_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // degenerate
    output logic                            m_axis_tuser
);
    import tbn_pkg::*;

    function automatic logic [VEC_W-1:0] vabs(input logic signed [VEC_W-1:0] v);
        vabs = v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
    endfunction

    function automatic logic [EDGE_W-1:0] eabs(input logic signed [EDGE_W-1:0] v);
        eabs = v[EDGE_W-1] ? EDGE_W'(-v) : EDGE_W'(v);
    endfunction

    back_state_t state_reg;
    back_state_t state_next;

    logic [STEP_W-1:0] cnt_reg;
    logic [STEP_W-1:0] cnt_next;
    logic [1:0]        idx_reg;
    logic              vsel_reg;
    logic              out_valid_reg;
    logic              pop;
    logic              out_load;

    logic signed [EDGE_W-1:0] e1_reg [3];
    logic signed [EDGE_W-1:0] e2_reg [3];
    logic signed [TEXD_W-1:0] du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic [EDGE_W-1:0]        em_reg;
    logic                     det_zero_reg, det_neg_reg;
    logic signed [VEC_W-1:0]  tvec_reg [3];
    logic signed [VEC_W-1:0]  bvec_reg [3];
    logic [VEC_W-1:0]         vm_reg [2];
    logic [SQ_W-1:0]          prod_reg, acc_reg;
    logic [SQ_W-1:0]          sq_n_reg, sq_root_reg, sq_bit_reg;
    logic [LEN_W-1:0]         len_reg;
    logic [LEN_W-1:0]         rem_reg;
    logic [Q_W-1:0]           quot_reg, nlow_reg;
    logic                     csign_reg;
    logic signed [OUT_W-1:0]  tres_reg [3];
    logic signed [OUT_W-1:0]  bres_reg [3];
    logic [OUT_TDATA_W-1:0]   out_data_reg;
    logic                     out_degen_reg;
    logic                     out_degen_reg_q;

    // combinational datapath
    logic [1:0]                      rd_idx;
    logic signed [VEC_W-1:0]         comp;
    logic [VEC_W-1:0]                comp_mag;
    logic [MAG_W-1:0]                comp_mag31;
    logic [2*MAG_W-1:0]              square;
    logic [EDGE_W-1:0]               a1, a2, em_max;
    logic                            edge_big;
    logic signed [2*TEXD_W-1:0]      dp1, dp2;
    logic signed [DET_W-1:0]         det_val;
    logic signed [MUL_W-1:0]         ea, eb, xa, xb;
    logic signed [TEXD_W-1:0]        ca, cb;
    logic signed [TEXD_W+MUL_W-1:0]  pa, pb;
    logic signed [VEC_W-1:0]         mul_res;
    logic [VEC_W-1:0]                tm, bm;
    logic [1:0]                      vbig, vsmall, vok;
    logic                            vshift_done, degen;
    logic [SQ_W-1:0]                 sq_trial;
    logic                            sq_ge;
    logic [NUM_W-1:0]                num;
    logic [LEN_W:0]                  rem2;
    logic                            div_ge;
    logic [Q_W-1:0]                  q_final;
    logic signed [OUT_W-1:0]         q_signed;

    always_comb
    begin
        rd_idx = (state_reg == ST_DINIT) ? idx_reg : cnt_reg[1:0];
        if (rd_idx == 2'd3)
        begin
            rd_idx = 2'd0;
        end
    end

    // component read for length and division
    assign comp       = vsel_reg ? bvec_reg[rd_idx] : tvec_reg[rd_idx];
    assign comp_mag   = vabs(comp);
    assign comp_mag31 = comp_mag[MAG_W-1:0];
    assign square     = comp_mag31 * comp_mag31;

    // edge magnitude maximum
    always_comb
    begin
        a1     = eabs(e1_reg[rd_idx]);
        a2     = eabs(e2_reg[rd_idx]);
        em_max = em_reg;
        if (a1 > em_max)
        begin
            em_max = a1;
        end
        if (a2 > em_max)
        begin
            em_max = a2;
        end
    end
    assign edge_big = (SQ_W'(em_reg) >= LIM30);

    // uv determinant, only sign and zero are kept
    assign dp1     = du1_reg * dv2_reg;
    assign dp2     = du2_reg * dv1_reg;
    assign det_val = DET_W'(dp1) - DET_W'(dp2);

    // tangent: dv2*e1 - dv1*e2, binormal: du1*e2 - du2*e1
    assign ea      = MUL_W'(e1_reg[rd_idx]);
    assign eb      = MUL_W'(e2_reg[rd_idx]);
    assign ca      = vsel_reg ? du1_reg : dv2_reg;
    assign cb      = vsel_reg ? du2_reg : dv1_reg;
    assign xa      = vsel_reg ? eb : ea;
    assign xb      = vsel_reg ? ea : eb;
    assign pa      = ca * xa;
    assign pb      = cb * xb;
    assign mul_res = VEC_W'(pa) - VEC_W'(pb);

    // vector magnitude maximum
    always_comb
    begin
        tm = vabs(tvec_reg[rd_idx]);
        bm = vabs(bvec_reg[rd_idx]);
        if (vm_reg[0] > tm)
        begin
            tm = vm_reg[0];
        end
        if (vm_reg[1] > bm)
        begin
            bm = vm_reg[1];
        end
    end

    // vector scaling window
    always_comb
    begin
        for (int v = 0; v < 2; v++)
        begin
            vbig[v]   = (SQ_W'(vm_reg[v]) >= LIM30);
            vsmall[v] = (SQ_W'(vm_reg[v]) < LIM29) && (vm_reg[v] != '0);
            vok[v]    = !vbig[v] && !vsmall[v];
        end
        vshift_done = &vok;
        degen       = det_zero_reg || (vm_reg[0] == '0) || (vm_reg[1] == '0);
    end

    // square root step
    assign sq_trial = sq_root_reg + sq_bit_reg;
    assign sq_ge    = (sq_n_reg >= sq_trial);

    // division step
    assign num      = (NUM_W'(comp_mag31) << FRAC_SH) + NUM_W'(len_reg >> 1);
    assign rem2     = {rem_reg, nlow_reg[Q_W-1]};
    assign div_ge   = (rem2 >= {1'b0, len_reg});
    assign q_final  = {quot_reg[Q_W-2:0], div_ge};
    assign q_signed = csign_reg ? -$signed(q_final) : $signed(q_final);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_avail)
                begin
                    state_next = ST_EMAX;
                end
            end
            ST_EMAX:
            begin
                if (cnt_reg == STEP_LAST3)
                begin
                    state_next = ST_ESHIFT;
                end
            end
            ST_ESHIFT:
            begin
                if (!edge_big)
                begin
                    state_next = ST_DET;
                end
            end
            ST_DET:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if ((cnt_reg == STEP_LAST3) && vsel_reg)
                begin
                    state_next = ST_VMAX;
                end
            end
            ST_VMAX:
            begin
                if (cnt_reg == STEP_LAST3)
                begin
                    state_next = ST_VSHIFT;
                end
            end
            ST_VSHIFT:
            begin
                if (vshift_done)
                begin
                    state_next = degen ? ST_EMIT : ST_SQ;
                end
            end
            ST_SQ:
            begin
                if (cnt_reg == STEP_LAST4)
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (cnt_reg == STEP_LASTSQ)
                begin
                    state_next = ST_DINIT;
                end
            end
            ST_DINIT:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg == STEP_LASTQ)
                begin
                    if (idx_reg != 2'd2)
                    begin
                        state_next = ST_DINIT;
                    end
                    else
                    begin
                        state_next = vsel_reg ? ST_EMIT : ST_SQ;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control strobes
    always_comb
    begin
        pop      = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                pop = q_avail;
            end
            ST_EMIT:
            begin
                out_load = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                pop      = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    assign q_hs.pop   = pop;
    assign q_hs.avail = q_avail;

    // step counter
    always_comb
    begin
        if ((state_next != state_reg) || ((state_reg == ST_MUL) && (cnt_reg == STEP_LAST3)))
        begin
            cnt_next = '0;
        end
        else
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= 2'd0;
            vsel_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (pop)
            begin
                vsel_reg <= 1'b0;
            end
            else if ((state_reg == ST_MUL) && (cnt_reg == STEP_LAST3))
            begin
                vsel_reg <= 1'b1;
            end
            else if (state_reg == ST_VSHIFT)
            begin
                vsel_reg <= 1'b0;
            end
            else if ((state_reg == ST_DIV) && (cnt_reg == STEP_LASTQ) && (idx_reg == 2'd2))
            begin
                vsel_reg <= 1'b1;
            end
            if (state_reg == ST_SQRT)
            begin
                idx_reg <= 2'd0;
            end
            else if ((state_reg == ST_DIV) && (cnt_reg == STEP_LASTQ))
            begin
                idx_reg <= idx_reg + 2'd1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                e1_reg[0] <= q_rec.e1_x;
                e1_reg[1] <= q_rec.e1_y;
                e1_reg[2] <= q_rec.e1_z;
                e2_reg[0] <= q_rec.e2_x;
                e2_reg[1] <= q_rec.e2_y;
                e2_reg[2] <= q_rec.e2_z;
                du1_reg   <= q_rec.du1;
                dv1_reg   <= q_rec.dv1;
                du2_reg   <= q_rec.du2;
                dv2_reg   <= q_rec.dv2;
                em_reg    <= '0;
            end
            ST_EMAX:
            begin
                em_reg <= em_max;
            end
            ST_ESHIFT:
            begin
                if (edge_big)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        e1_reg[i] <= e1_reg[i] >>> 1;
                        e2_reg[i] <= e2_reg[i] >>> 1;
                    end
                    em_reg <= em_reg >> 1;
                end
            end
            ST_DET:
            begin
                det_zero_reg <= (det_val == '0);
                det_neg_reg  <= det_val[DET_W-1];
                vm_reg[0]    <= '0;
                vm_reg[1]    <= '0;
            end
            ST_MUL:
            begin
                if (vsel_reg)
                begin
                    bvec_reg[rd_idx] <= mul_res;
                end
                else
                begin
                    tvec_reg[rd_idx] <= mul_res;
                end
            end
            ST_VMAX:
            begin
                vm_reg[0] <= tm;
                vm_reg[1] <= bm;
            end
            ST_VSHIFT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (vbig[0])
                    begin
                        tvec_reg[i] <= tvec_reg[i] >>> 1;
                    end
                    else if (vsmall[0])
                    begin
                        tvec_reg[i] <= tvec_reg[i] <<< 1;
                    end
                    if (vbig[1])
                    begin
                        bvec_reg[i] <= bvec_reg[i] >>> 1;
                    end
                    else if (vsmall[1])
                    begin
                        bvec_reg[i] <= bvec_reg[i] <<< 1;
                    end
                end
                for (int v = 0; v < 2; v++)
                begin
                    if (vbig[v])
                    begin
                        vm_reg[v] <= vm_reg[v] >> 1;
                    end
                    else if (vsmall[v])
                    begin
                        vm_reg[v] <= vm_reg[v] << 1;
                    end
                end
                out_degen_reg <= degen;
            end
            ST_SQ:
            begin
                prod_reg <= SQ_W'(square);
                if (cnt_reg == '0)
                begin
                    acc_reg <= '0;
                end
                else
                begin
                    acc_reg <= acc_reg + prod_reg;
                end
                sq_n_reg    <= acc_reg + prod_reg;
                sq_root_reg <= '0;
                sq_bit_reg  <= SQRT_BIT0;
            end
            ST_SQRT:
            begin
                if (sq_ge)
                begin
                    sq_n_reg    <= sq_n_reg - sq_trial;
                    sq_root_reg <= (sq_root_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_root_reg <= sq_root_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
                len_reg    <= sq_ge ? LEN_W'((sq_root_reg >> 1) + sq_bit_reg)
                                    : LEN_W'(sq_root_reg >> 1);
            end
            ST_DINIT:
            begin
                rem_reg   <= LEN_W'(num[NUM_W-1:Q_W]);
                nlow_reg  <= num[Q_W-1:0];
                quot_reg  <= '0;
                csign_reg <= comp[VEC_W-1] ^ det_neg_reg;
            end
            ST_DIV:
            begin
                rem_reg  <= div_ge ? LEN_W'(rem2 - {1'b0, len_reg}) : LEN_W'(rem2);
                nlow_reg <= nlow_reg << 1;
                quot_reg <= q_final;
                if (cnt_reg == STEP_LASTQ)
                begin
                    if (vsel_reg)
                    begin
                        bres_reg[idx_reg] <= q_signed;
                    end
                    else
                    begin
                        tres_reg[idx_reg] <= q_signed;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    out_data_reg <= out_degen_reg ? '0 :
                        {bres_reg[2], bres_reg[1], bres_reg[0],
                         tres_reg[2], tres_reg[1], tres_reg[0]};
                end
            end
            default:
            begin
                em_reg <= em_reg;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_degen_reg_q;

    // degenerate flag held with the result
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_degen_reg_q <= out_degen_reg;
        end
    end

endmodule

// ----- rtl/triangle_tangent_binormal.sv -----
`timescale 1ns / 1ps
// Per-triangle tangent and binormal unit vectors from a triangle-list vertex
// stream. One vertex enters per request while the triangle queue has room;
// every third vertex (counting from a vertex with start_mesh set) closes a
// triangle and yields one result of six Q2.14 components and a degenerate
// flag. A front end assembles corners and feeds a two-entry triangle queue,
// so vertices keep flowing while the back end works. The back end is one
// sequencer around a shared multiply pair, a bit-serial square root (a sum of
// squares, then 32 root steps per vector) and a restoring divider (one load
// and 16 steps per component). Per triangle the back end loads the record,
// finds the edge maximum, scales the edges, takes the determinant, forms the
// products, finds the vector maximum and scales the vectors, computes the two
// lengths and six divisions and loads the output; scaling shifts one bit at a
// time. It handles one triangle at a time and so sets the sustained rate.
// Depends on tbn_pkg, tbn_front, tbn_fifo and tbn_back.

module triangle_tangent_binormal (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // pos_x, pos_y, pos_z, tex_u, tex_v from the lowest bit up
    input  logic [tbn_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // start_mesh
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tangent_x, tangent_y, tangent_z, binormal_x, binormal_y, binormal_z
    output logic [tbn_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // degenerate
    output logic                            m_axis_tuser
);
    import tbn_pkg::*;

    logic     q_push;
    logic     q_full;
    logic     q_avail;
    tri_rec_t q_in;
    tri_rec_t q_out;
    q_hs_t    q_hs;

    // corner assembly
    tbn_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_rec         (q_in)
    );

    // triangle queue
    tbn_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_in),
        .full  (q_full),
        .hs_in (q_hs),
        .avail (q_avail),
        .dout  (q_out)
    );

    // normalization sequencer
    tbn_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_avail       (q_avail),
        .q_rec         (q_out),
        .q_hs          (q_hs),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ----- rtl/tbn_checker.sv -----
`timescale 1ns / 1ps
// port-level checks on the triangle tangent/binormal block, bound to the top
// level; uses tbn_pkg for the stream widths

module tbn_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [tbn_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                            s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [tbn_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tuser
);
    import tbn_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // degenerate results carry zero vectors
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("degenerate result with nonzero vectors");

    // a good tangent is a unit vector, never all zero
    a_unit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[3*OUT_W-1:0] != '0)
        else $error("unit tangent is zero");

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind triangle_tangent_binormal tbn_checker u_tbn_checker (.*);
